[rtl/fpfir_pkg.sv]
// ----------------------------------------------------------------------------
// fpfir_pkg: shared definitions for the fixed-point FIR filter core
// Field widths, stream packing offsets, mode codes and the command and
// status structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package fpfir_pkg;

   // Default filter configuration.
   localparam int TAPS_DEF      = 24;
   localparam int FRAC_BITS_DEF = 8;

   // Field widths.
   localparam int IDX_W    = 5;
   localparam int WEIGHT_W = 16;
   localparam int SAMPLE_W = 24;
   localparam int RESULT_W = 32;
   localparam int PROD_W   = SAMPLE_W + WEIGHT_W;

   // Stream word packing.
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 32;
   localparam int IDX_LSB    = 0;
   localparam int WEIGHT_LSB = IDX_LSB + IDX_W;
   localparam int SAMPLE_LSB = WEIGHT_LSB + WEIGHT_W;

   // Item kinds carried in tuser.
   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_FILTER = 1'b1;

   // Controller to datapath commands.
   typedef struct packed {
      logic load_weight;  // write one coefficient from the request word
      logic shift_in;     // push a new sample and clear the accumulator
      logic mac_en;       // multiply the head taps and rotate both lines
      logic load_out;     // move the saturated sum into the output register
   } fpfir_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic out_busy;     // output register holds a word not yet taken
   } fpfir_status_type;

endpackage

[rtl/fpfir_ctrl.sv]
// ----------------------------------------------------------------------------
// fpfir_ctrl: sequencing state machine of the FIR filter core
// Accepts request words, walks the taps once per sample and hands the
// finished sum to the output register.
// ----------------------------------------------------------------------------
module fpfir_ctrl #(
   parameter int TAPS = fpfir_pkg::TAPS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic                        req_mode,
   input  fpfir_pkg::fpfir_status_type status,
   output fpfir_pkg::fpfir_cmd_type    cmd
);
   import fpfir_pkg::*;

   localparam int CNT_W = $clog2(TAPS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN_A,
      ST_DRAIN_B,
      ST_FINISH
   } state_type;

   state_type        state_ff;
   logic             rdy_ff;
   logic             mac_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             accept;

   assign accept     = req_tvalid & rdy_ff;
   assign req_tready = rdy_ff;

   always_comb begin
      cmd.load_weight = accept & (req_mode == MODE_LOAD);
      cmd.shift_in    = accept & (req_mode == MODE_FILTER);
      cmd.mac_en      = mac_ff;
      cmd.load_out    = (state_ff == ST_FINISH) & ~status.out_busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rdy_ff   <= 1'b1;
         mac_ff   <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && (req_mode == MODE_FILTER)) begin
                  state_ff <= ST_MAC;
                  rdy_ff   <= 1'b0;
                  mac_ff   <= 1'b1;
                  cnt_ff   <= '0;
               end
            end
            ST_MAC: begin
               if (cnt_ff == CNT_W'(TAPS - 1)) begin
                  state_ff <= ST_DRAIN_A;
                  mac_ff   <= 1'b0;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_DRAIN_A: begin
               state_ff <= ST_DRAIN_B;
            end
            ST_DRAIN_B: begin
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               if (!status.out_busy) begin
                  state_ff <= ST_IDLE;
                  rdy_ff   <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               rdy_ff   <= 1'b1;
               mac_ff   <= 1'b0;
            end
         endcase
      end
   end

endmodule

[rtl/fpfir_dp.sv]
// ----------------------------------------------------------------------------
// fpfir_dp: datapath of the FIR filter core
// Delay line and coefficient table as rotating registers, one shared
// multiplier, truncating scale stage, accumulator, saturation and the
// output register.
// ----------------------------------------------------------------------------
module fpfir_dp #(
   parameter int TAPS      = fpfir_pkg::TAPS_DEF,
   parameter int FRAC_BITS = fpfir_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  fpfir_pkg::fpfir_cmd_type              cmd,
   output fpfir_pkg::fpfir_status_type           status,
   input  logic [fpfir_pkg::IDX_W-1:0]           tap_index,
   input  logic signed [fpfir_pkg::WEIGHT_W-1:0] tap_weight,
   input  logic signed [fpfir_pkg::SAMPLE_W-1:0] sample,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic signed [fpfir_pkg::RESULT_W-1:0] filtered
);
   import fpfir_pkg::*;

   localparam int ADDR_W = $clog2(TAPS);
   localparam int CMP_W  = (IDX_W > ADDR_W) ? IDX_W + 1 : ADDR_W + 1;
   localparam int ACC_W  = PROD_W + ADDR_W + 1;
   localparam logic [PROD_W-1:0] RND_BIAS = PROD_W'((64'd1 << FRAC_BITS) - 64'd1);
   localparam logic signed [ACC_W-1:0] SAT_MAX = {{(ACC_W-RESULT_W){1'b0}}, 32'h7FFF_FFFF};
   localparam logic signed [ACC_W-1:0] SAT_MIN = {{(ACC_W-RESULT_W){1'b1}}, 32'h8000_0000};

   logic signed [SAMPLE_W-1:0] dly_ff [TAPS];
   logic signed [SAMPLE_W-1:0] dly_in [TAPS];
   logic signed [WEIGHT_W-1:0] wgt_ff [TAPS];
   logic signed [WEIGHT_W-1:0] wgt_in [TAPS];

   logic signed [PROD_W-1:0]   prod_ff;
   logic                       prod_vld_ff;
   logic signed [PROD_W-1:0]   quot_ff;
   logic signed [PROD_W-1:0]   quot_in;
   logic                       quot_vld_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic signed [RESULT_W-1:0] sat_in;
   logic                       rsp_vld_ff;
   logic signed [RESULT_W-1:0] rsp_data_ff;
   logic [CMP_W-1:0]           idx_ext;

   assign idx_ext = CMP_W'(tap_index);

   // Both lines rotate toward position zero during the walk, so after TAPS
   // steps they are back in their original alignment.
   always_comb begin
      for (int i = 0; i < TAPS; i++) begin
         dly_in[i] = dly_ff[i];
         wgt_in[i] = wgt_ff[i];
         if (cmd.mac_en) begin
            dly_in[i] = (i == TAPS - 1) ? dly_ff[0] : dly_ff[(i + 1) % TAPS];
            wgt_in[i] = (i == TAPS - 1) ? wgt_ff[0] : wgt_ff[(i + 1) % TAPS];
         end else if (cmd.shift_in) begin
            dly_in[i] = (i == 0) ? sample : dly_ff[(i + TAPS - 1) % TAPS];
         end else if (cmd.load_weight && (idx_ext == CMP_W'(i))) begin
            wgt_in[i] = tap_weight;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TAPS; i++) begin
            dly_ff[i] <= '0;
            wgt_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < TAPS; i++) begin
            dly_ff[i] <= dly_in[i];
            wgt_ff[i] <= wgt_in[i];
         end
      end
   end

   // Division by 2^FRAC_BITS truncating toward zero: bias negatives first.
   always_comb begin
      quot_in = $signed(prod_ff + (prod_ff[PROD_W-1] ? RND_BIAS : '0)) >>> FRAC_BITS;
   end

   always_comb begin
      if (acc_ff > SAT_MAX) begin
         sat_in = SAT_MAX[RESULT_W-1:0];
      end else if (acc_ff < SAT_MIN) begin
         sat_in = SAT_MIN[RESULT_W-1:0];
      end else begin
         sat_in = acc_ff[RESULT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= dly_ff[0] * wgt_ff[0];
      quot_ff <= quot_in;
      if (cmd.shift_in) begin
         acc_ff <= '0;
      end else if (quot_vld_ff) begin
         acc_ff <= acc_ff + {{(ACC_W-PROD_W){quot_ff[PROD_W-1]}}, quot_ff};
      end
      if (cmd.load_out) begin
         rsp_data_ff <= sat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         quot_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         prod_vld_ff <= cmd.mac_en;
         quot_vld_ff <= prod_vld_ff;
         if (cmd.load_out) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   assign status.out_busy = rsp_vld_ff & ~rsp_tready;
   assign rsp_tvalid      = rsp_vld_ff;
   assign filtered        = rsp_data_ff;

endmodule

[rtl/fixed_point_fir_filter_core.sv]
// ----------------------------------------------------------------------------
// fixed_point_fir_filter_core: direct-form FIR filter on Q.8 samples
// Coefficient loads and filter samples arrive on one stream; each sample
// gives one saturated 32-bit result on the response stream.
// ----------------------------------------------------------------------------
// A filter word holds off further requests until its sum has gone to the
// output register; the walk over the taps is paced by the single shared
// multiplier that visits one tap per cycle. A coefficient load is written
// as it is accepted. A finished result may wait in the output register
// while the next word is accepted and computed.
// Reset (synchronous, active high) clears the delay line, the coefficient
// table and all control state.
module fixed_point_fir_filter_core #(
   parameter int TAPS      = fpfir_pkg::TAPS_DEF,
   parameter int FRAC_BITS = fpfir_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request stream.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata from bit 0: tap_index[4:0], tap_weight[20:5], sample[44:21], zero fill.
   input  logic [fpfir_pkg::REQ_DATA_W-1:0]    req_tdata,
   // tuser: mode (0 loads a coefficient, 1 filters one sample).
   input  logic                                req_tuser,
   // Response stream.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata from bit 0: filtered[31:0].
   output logic [fpfir_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import fpfir_pkg::*;

   fpfir_cmd_type              cmd;
   fpfir_status_type           status;
   logic signed [RESULT_W-1:0] filtered;

   // The controller owns the request handshake and steps the datapath
   // through one multiply-accumulate per tap, then the pipeline drain states
   // ST_DRAIN_A and ST_DRAIN_B before the sum is saturated into the output register.
   fpfir_ctrl #(
      .TAPS (TAPS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath keeps the delay line and coefficient table as rotating
   // registers so the multiplier always reads the head entries. Out-of-range
   // coefficient indexes match no entry and are dropped.
   fpfir_dp #(
      .TAPS      (TAPS),
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .tap_index  (req_tdata[IDX_LSB +: IDX_W]),
      .tap_weight (req_tdata[WEIGHT_LSB +: WEIGHT_W]),
      .sample     (req_tdata[SAMPLE_LSB +: SAMPLE_W]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .filtered   (filtered)
   );

   assign rsp_tdata = RSP_DATA_W'(filtered);

endmodule
